FILE: rtl/bcam_pkg.sv
`timescale 1ns / 1ps

package bcam_pkg;

  localparam int NUM_CELLS   = 4;
  localparam int NUM_SLOTS   = 6;
  localparam int AVG_SHIFT   = 5;
  localparam int SAMPLE_BITS = 10;

  localparam int SLOT_BITS   = 3;
  localparam int CELL_BITS   = SAMPLE_BITS + 1;
  localparam int IDX_BITS    = 2;
  localparam int CIDX_BITS   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SUM_BITS    = SAMPLE_BITS + AVG_SHIFT;

  localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int S_TUSER_BITS = SLOT_BITS;
  localparam int M_FIELD_BITS = SAMPLE_BITS + CELL_BITS + 2 * IDX_BITS;
  localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0]       sample_t;
  typedef logic [AVG_SHIFT-1:0]         resid_t;
  typedef logic signed [CELL_BITS-1:0]  cell_t;
  typedef logic [IDX_BITS-1:0]          idx_t;

  typedef struct packed {
    idx_t    max_cell;
    idx_t    min_cell;
    cell_t   cell_voltage;
    sample_t slot_value;
  } result_t;

endpackage

FILE: rtl/battery_cell_average_monitor_top.sv
`timescale 1ns / 1ps

// Smooths stacked cell tap samples with a 1/32 exponential average that
// carries its dropped bits, derives each cell voltage as the difference to
// the tap below, and tracks the lowest and highest cell of the current scan
// (restarted by slot 0). Slots 4 and 5 pass the raw sample through, and any
// higher slot changes nothing and returns a zero value and cell voltage with
// the current lowest and highest cell. One word is accepted every cycle unless
// the input register is full and the output register is stalled; each word
// moves from the input register through the averaging update into the output register,
// which holds it until it is taken.

module battery_cell_average_monitor_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample
  input  logic [bcam_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
  // slot
  input  logic [bcam_pkg::S_TUSER_BITS-1:0] s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // slot_value, cell_voltage, min_cell, max_cell
  output logic [bcam_pkg::M_TDATA_BITS-1:0] m_axis_tdata
);

  logic                            in_valid_q, in_valid_d;
  logic [bcam_pkg::SLOT_BITS-1:0]  in_slot_q;
  bcam_pkg::sample_t               in_sample_q;
  logic                            out_valid_q, out_valid_d;
  bcam_pkg::result_t               out_res_q;
  bcam_pkg::result_t               core_res;
  logic                            s_accept;
  logic                            out_free;
  logic                            advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  bcam_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .slot_i   (in_slot_q),
    .sample_i (in_sample_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_slot_q   <= s_axis_tuser;
      in_sample_q <= s_axis_tdata[bcam_pkg::SAMPLE_BITS-1:0];
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bcam_pkg::M_TDATA_BITS'(out_res_q);

endmodule

FILE: rtl/bcam_core.sv
`timescale 1ns / 1ps

module bcam_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [bcam_pkg::SLOT_BITS-1:0] slot_i,
  input  bcam_pkg::sample_t             sample_i,
  output bcam_pkg::result_t             result_o
);

  bcam_pkg::sample_t avg_q   [bcam_pkg::NUM_SLOTS];
  bcam_pkg::sample_t avg_d   [bcam_pkg::NUM_SLOTS];
  bcam_pkg::resid_t  resid_q [bcam_pkg::NUM_CELLS];
  bcam_pkg::resid_t  resid_d [bcam_pkg::NUM_CELLS];
  bcam_pkg::cell_t   cell_q  [bcam_pkg::NUM_CELLS];
  bcam_pkg::cell_t   cell_d  [bcam_pkg::NUM_CELLS];
  bcam_pkg::idx_t    lo_q, lo_d, hi_q, hi_d;

  logic                                is_cell;
  logic                                in_range;
  logic [bcam_pkg::CIDX_BITS-1:0]      cidx;
  logic [bcam_pkg::CIDX_BITS-1:0]      lo_cidx, hi_cidx;
  bcam_pkg::sample_t                   old_avg;
  bcam_pkg::sample_t                   below_avg;
  bcam_pkg::resid_t                    old_resid;
  logic [bcam_pkg::SUM_BITS-1:0]       sum;
  bcam_pkg::sample_t                   new_avg;
  bcam_pkg::cell_t                     cell_volt;
  bcam_pkg::cell_t                     lo_val, hi_val;
  bcam_pkg::sample_t                   value;

  assign is_cell  = 32'(slot_i) < bcam_pkg::NUM_CELLS;
  assign in_range = 32'(slot_i) < bcam_pkg::NUM_SLOTS;
  assign cidx     = bcam_pkg::CIDX_BITS'(slot_i);
  assign lo_cidx  = bcam_pkg::CIDX_BITS'(lo_q);
  assign hi_cidx  = bcam_pkg::CIDX_BITS'(hi_q);

  always_comb begin
    old_avg   = '0;
    below_avg = '0;
    for (int i = 0; i < bcam_pkg::NUM_CELLS; i++) begin
      if (cidx == bcam_pkg::CIDX_BITS'(i)) begin
        old_avg = avg_q[i];
      end
      if (i > 0 && cidx == bcam_pkg::CIDX_BITS'(i)) begin
        below_avg = avg_q[(i > 0) ? i - 1 : 0];
      end
    end
    old_resid = resid_q[cidx];
  end

  // Old weight is 2^AVG_SHIFT - 1, so 31*old is (old << 5) - old.
  assign sum = ({old_avg, bcam_pkg::AVG_SHIFT'(0)} - bcam_pkg::SUM_BITS'(old_avg))
             + bcam_pkg::SUM_BITS'(sample_i) + bcam_pkg::SUM_BITS'(old_resid);
  assign new_avg = sum[bcam_pkg::SUM_BITS-1:bcam_pkg::AVG_SHIFT];

  assign cell_volt = $signed({1'b0, new_avg}) - $signed({1'b0, below_avg});

  // The new cell voltage is forwarded into the compare, so an index that
  // points at this slot sees the new value.
  assign lo_val = (lo_cidx == cidx) ? cell_volt : cell_q[lo_cidx];
  assign hi_val = (hi_cidx == cidx) ? cell_volt : cell_q[hi_cidx];

  always_comb begin
    for (int i = 0; i < bcam_pkg::NUM_SLOTS; i++) begin
      avg_d[i] = avg_q[i];
    end
    for (int i = 0; i < bcam_pkg::NUM_CELLS; i++) begin
      resid_d[i] = resid_q[i];
      cell_d[i]  = cell_q[i];
    end
    lo_d  = lo_q;
    hi_d  = hi_q;
    value = '0;
    if (is_cell) begin
      avg_d[slot_i]  = new_avg;
      resid_d[cidx]  = sum[bcam_pkg::AVG_SHIFT-1:0];
      cell_d[cidx]   = cell_volt;
      value          = new_avg;
      if (slot_i == '0) begin
        lo_d = '0;
        hi_d = '0;
      end else begin
        if (cell_volt < lo_val) begin
          lo_d = bcam_pkg::IDX_BITS'(slot_i);
        end
        if (cell_volt > hi_val) begin
          hi_d = bcam_pkg::IDX_BITS'(slot_i);
        end
      end
    end else if (in_range) begin
      avg_d[slot_i] = sample_i;
      value         = sample_i;
    end
  end

  always_comb begin
    result_o.slot_value   = value;
    result_o.cell_voltage = is_cell ? cell_volt : '0;
    result_o.min_cell     = lo_d;
    result_o.max_cell     = hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bcam_pkg::NUM_SLOTS; i++) begin
        avg_q[i] <= '0;
      end
      for (int i = 0; i < bcam_pkg::NUM_CELLS; i++) begin
        resid_q[i] <= '0;
        cell_q[i]  <= '0;
      end
      lo_q <= '0;
      hi_q <= '0;
    end else if (en_i) begin
      avg_q   <= avg_d;
      resid_q <= resid_d;
      cell_q  <= cell_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

endmodule

FILE: tb/sv/tb_battery_cell_average_monitor_top.sv
`timescale 1ns / 1ps

module tb_battery_cell_average_monitor_top;
  import bcam_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1830;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

  typedef struct {
    logic [SLOT_BITS-1:0] slot;
    sample_t              sample;
  } reading_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic [S_TUSER_BITS-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_axis_tdata;

  battery_cell_average_monitor_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  reading_t pending_q[$];
  result_t  expected_q[$];

  sample_t tap_avg[NUM_SLOTS];
  resid_t  tap_resid[NUM_CELLS];
  cell_t   cell_mv[NUM_CELLS];
  idx_t    low_idx;
  idx_t    high_idx;

  int n_queued = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_scans = 0;
  int n_stray = 0;
  int n_errors = 0;
  int send_gap = 0;
  int stall_left = 0;
  int stuck_cycles = 0;
  bit quiet_run = 1'b1;
  reading_t next_word;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t predict_reading(input logic [SLOT_BITS-1:0] slot,
                                              input sample_t smp);
    result_t r;
    int sum;
    int cv;
    r = '0;
    if (slot < NUM_CELLS) begin
      sum = ((1 << AVG_SHIFT) - 1) * int'(tap_avg[slot]) + int'(smp)
            + int'(tap_resid[slot]);
      tap_resid[slot] = resid_t'(sum);
      tap_avg[slot] = sample_t'(sum >> AVG_SHIFT);
      cv = int'(tap_avg[slot]);
      if (slot == 0) begin
        low_idx = '0;
        high_idx = '0;
      end else begin
        cv = cv - int'(tap_avg[slot - 1]);
      end
      cell_mv[slot] = cell_t'(cv);
      if (slot != 0) begin
        if (cell_mv[slot] < cell_mv[low_idx]) low_idx = idx_t'(slot);
        if (cell_mv[slot] > cell_mv[high_idx]) high_idx = idx_t'(slot);
      end
      r.slot_value = tap_avg[slot];
      r.cell_voltage = cell_mv[slot];
    end else if (slot < NUM_SLOTS) begin
      tap_avg[slot] = smp;
      r.slot_value = smp;
    end
    r.min_cell = low_idx;
    r.max_cell = high_idx;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if ($urandom_range(0, 63) == 0) quiet_run = ~quiet_run;
    if (quiet_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_reading(input int slot, input int smp);
    reading_t w;
    w.slot = SLOT_BITS'(slot);
    w.sample = sample_t'(smp);
    pending_q.push_back(w);
    n_queued++;
    if (slot >= NUM_SLOTS) n_stray++;
  endfunction

  function automatic int near_target(input int target);
    int v;
    v = target + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  initial begin
    int target[NUM_CELLS];
    int acc;
    int kind;
    for (int k = 0; k < NUM_SLOTS; k++) tap_avg[k] = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      tap_resid[k] = '0;
      cell_mv[k] = '0;
      target[k] = 0;
    end
    low_idx = '0;
    high_idx = '0;

    // Full-scale and zero samples on every used slot, unused slots, an
    // out-of-order scan, and alternating bit patterns.
    queue_reading(0, SAMPLE_MAX);
    queue_reading(1, 0);
    queue_reading(2, SAMPLE_MAX);
    queue_reading(3, 0);
    queue_reading(4, SAMPLE_MAX);
    queue_reading(5, 0);
    queue_reading(6, 'h155);
    queue_reading(7, SAMPLE_MAX);
    queue_reading(4, 0);
    queue_reading(5, SAMPLE_MAX);
    queue_reading(3, SAMPLE_MAX);
    queue_reading(2, 0);
    queue_reading(1, SAMPLE_MAX);
    queue_reading(0, 0);
    queue_reading(2, SAMPLE_MAX);
    queue_reading(1, 'h2AA);
    queue_reading(3, 'h155);
    queue_reading(0, 'h2AA);
    queue_reading(1, 'h155);
    queue_reading(3, SAMPLE_MAX);
    queue_reading(7, 0);
    queue_reading(0, SAMPLE_MAX);

    while (n_queued < 22 + RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        if (n_scans % 8 == 0 || $urandom_range(0, 7) == 0) begin
          acc = 0;
          for (int k = 0; k < NUM_CELLS; k++) begin
            if ($urandom_range(0, 2) == 0) begin
              target[k] = $urandom_range(0, SAMPLE_MAX);
            end else begin
              acc += $urandom_range(0, 255);
              target[k] = acc;
            end
          end
        end
        for (int k = 0; k < NUM_CELLS; k++) queue_reading(k, near_target(target[k]));
        queue_reading(4, $urandom_range(0, SAMPLE_MAX));
        queue_reading(5, $urandom_range(0, SAMPLE_MAX));
        n_scans++;
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 6)) begin
          acc = $urandom_range(0, NUM_CELLS - 1);
          queue_reading(acc, near_target(target[acc]));
        end
      end else begin
        queue_reading($urandom_range(0, 7), $urandom_range(0, SAMPLE_MAX));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent < n_queued || expected_q.size() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("Sent %0d words (%0d full scans, %0d to unused slots), checked %0d results.",
             n_sent, n_scans, n_stray, n_checked);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing.", n_errors, expected_q.size());
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_reading(s_axis_tuser, s_axis_tdata[SAMPLE_BITS-1:0]));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          next_word = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= S_TDATA_BITS'(next_word.sample);
          s_axis_tuser <= next_word.slot;
          send_gap = idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[M_FIELD_BITS-1:0]);
        n_checked++;
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Unexpected word: value %0d cell %0d min %0d max %0d",
                     got.slot_value, got.cell_voltage, got.min_cell, got.max_cell);
        end else begin
          want = expected_q.pop_front();
          if (got.slot_value !== want.slot_value || got.cell_voltage !== want.cell_voltage ||
              got.min_cell !== want.min_cell || got.max_cell !== want.max_cell) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("Mismatch on result %0d: expected value %0d cell %0d min %0d max %0d",
                       n_checked, want.slot_value, want.cell_voltage, want.min_cell,
                       want.max_cell);
              $display("  got value %0d cell %0d min %0d max %0d",
                       got.slot_value, got.cell_voltage, got.min_cell, got.max_cell);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("No word moved for %0d cycles.", STUCK_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule
